>>> rtl/core/mqtt_pkg.sv
// Package for the MQTT control packet parser: phase, field and status codes.
// Used by mqtt_step and mqtt_control_packet_parser; no dependencies.
`timescale 1ns / 1ps
package mqtt_pkg;
    typedef enum logic [4:0] {
        PH_IDLE, PH_REMLEN, PH_PNAME_LEN, PH_PNAME, PH_LEVEL, PH_CFLAGS, PH_KEEPALIVE,
        PH_CID_LEN, PH_CID, PH_WTOP_LEN, PH_WTOP, PH_WMSG_LEN, PH_WMSG, PH_CACK_FLAGS,
        PH_CACK_CODE, PH_PUB_TLEN, PH_PUB_TOPIC, PH_PUB_ID, PH_PUB_DATA, PH_PKTID,
        PH_SUB_TLEN, PH_SUB_TOPIC, PH_SUB_QOS, PH_SUBACK_CODE, PH_UNS_TLEN, PH_UNS_TOPIC,
        PH_DONE
    } t_phase;

    localparam logic [2:0] ST_BUSY = 3'd0;
    localparam logic [2:0] ST_OK = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_OOB = 3'd3;
    localparam logic [2:0] ST_FLAGS = 3'd4;
    localparam logic [2:0] ST_PKTID0 = 3'd5;
    localparam logic [2:0] ST_UNKNOWN = 3'd6;

    localparam logic [3:0] K_NONE = 4'd0;
    localparam logic [3:0] K_HEADER = 4'd1;
    localparam logic [3:0] K_REMLEN = 4'd2;
    localparam logic [3:0] K_LEVEL = 4'd3;
    localparam logic [3:0] K_FLAGS = 4'd4;
    localparam logic [3:0] K_KEEPALIVE = 4'd5;
    localparam logic [3:0] K_PKTID = 4'd6;
    localparam logic [3:0] K_STRING = 4'd7;
    localparam logic [3:0] K_PAYLOAD = 4'd8;
    localparam logic [3:0] K_CODE = 4'd9;
    localparam logic [3:0] K_TUPLE_END = 4'd10;
    localparam logic [3:0] K_STATUS = 4'd11;

    localparam logic [3:0] PT_CONNECT = 4'd1;
    localparam logic [3:0] PT_CONNACK = 4'd2;
    localparam logic [3:0] PT_PUBLISH = 4'd3;
    localparam logic [3:0] PT_PUBACK = 4'd4;
    localparam logic [3:0] PT_SUBSCRIBE = 4'd8;
    localparam logic [3:0] PT_SUBACK = 4'd9;
    localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] PT_DISCONNECT = 4'd14;

    localparam logic [7:0] SUBACK_FAILURE = 8'd128;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  status;
        logic [7:0]  header;
        logic [27:0] remlen;
        logic [2:0]  digits;
        logic [15:0] fcount;
        logic [15:0] slen;
        logic [16:0] vhdr;
        logic [7:0]  cflags;
        logic [15:0] tuples;
        logic        gfail;
    } t_state;

    typedef struct packed {
        logic [3:0]  pkind;
        logic [3:0]  fkind;
        logic [1:0]  sel;
        logic [27:0] value;
        logic [15:0] index;
        logic        failed;
        logic [2:0]  status;
        logic        done;
    } t_result;
endpackage

>>> rtl/core/mqtt_control_packet_parser.sv
// Top level of the MQTT 3.1.1 control packet parser: byte channel in, tagged result out.
// Depends on mqtt_pkg and mqtt_step.
//
// Usage: each received byte is a transfer on the input channel (i_valid/o_ready) with
// i_first_byte on the fixed header byte and i_end_of_buffer on the last byte of the
// buffer. Every byte yields exactly one result transfer (o_valid/i_ready) that names
// the field the byte belongs to, its value, and the parse status.
// The result of a byte is registered and presented in the cycle after it is accepted.
// Throughput is one byte per cycle while the receiver does not stall; the field state
// machine advances in combinational logic from the parser state to the result register.
// While the receiver stalls, the result register holds and o_ready follows i_ready,
// so the input is accepted whenever the result register is empty or being drained.
// Reset clears the parser to awaiting a fixed header and empties the result register.
`timescale 1ns / 1ps
module mqtt_control_packet_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_first_byte,
    input  logic        i_end_of_buffer,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_packet_kind,
    output logic [3:0]  o_field_kind,
    output logic [1:0]  o_string_select,
    output logic [27:0] o_field_value,
    output logic [15:0] o_tuple_index,
    output logic        o_tuple_failed,
    output logic [2:0]  o_parse_status,
    output logic        o_packet_done
);
    import mqtt_pkg::*;

    t_state  r_st, n_st;
    t_result r_res, n_res;
    logic    r_valid;
    logic    accept;

    mqtt_step u_step (
        .i_st    (r_st),
        .i_byte  (i_in_byte),
        .i_first (i_first_byte),
        .i_last  (i_end_of_buffer),
        .o_st    (n_st),
        .o_res   (n_res)
    );

    assign o_ready = !r_valid || i_ready;
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) r_st <= n_st;
            if (accept) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_packet_kind = r_res.pkind;
    assign o_field_kind = r_res.fkind;
    assign o_string_select = r_res.sel;
    assign o_field_value = r_res.value;
    assign o_tuple_index = r_res.index;
    assign o_tuple_failed = r_res.failed;
    assign o_parse_status = r_res.status;
    assign o_packet_done = r_res.done;

    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_packet_done == (o_parse_status != ST_BUSY)))
        else $error("done flag disagrees with status");
    a_header_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_first_byte) |=> (o_field_kind == K_HEADER))
        else $error("header byte did not give a header result");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_res))
        else $error("result changed while stalled");
endmodule

>>> rtl/core/mqtt_step.sv
// Combinational next-state and result logic for one received byte.
// Depends on mqtt_pkg.
`timescale 1ns / 1ps
module mqtt_step (
    input  mqtt_pkg::t_state  i_st,
    input  logic [7:0]        i_byte,
    input  logic              i_first,
    input  logic              i_last,
    output mqtt_pkg::t_state  o_st,
    output mqtt_pkg::t_result o_res
);
    import mqtt_pkg::*;

    t_state      s;
    logic [3:0]  kind;
    logic [1:0]  sel;
    logic [27:0] value;
    logic [15:0] index;
    logic        failed;
    logic [15:0] pair;
    logic        pair_done;
    logic [15:0] fc_inc;
    logic        str_done;
    logic [15:0] tup_inc;
    logic [27:0] remlen_add;
    logic [3:0]  ptype;
    logic [3:0]  hflags;

    always_comb begin
        pair = (i_st.fcount == 16'd0) ? {i_byte, 8'd0} : {i_st.slen[15:8], i_byte};
        pair_done = (i_st.fcount != 16'd0);
        fc_inc = i_st.fcount + 16'd1;
        str_done = (fc_inc >= i_st.slen);
        tup_inc = (i_st.tuples == 16'hFFFF) ? i_st.tuples : i_st.tuples + 16'd1;
        ptype = i_st.header[7:4];
        hflags = i_st.header[3:0];
        case (i_st.digits)
            3'd0: remlen_add = {21'd0, i_byte[6:0]};
            3'd1: remlen_add = {14'd0, i_byte[6:0], 7'd0};
            3'd2: remlen_add = {7'd0, i_byte[6:0], 14'd0};
            default: remlen_add = {i_byte[6:0], 21'd0};
        endcase
    end

    always_comb begin
        s = i_st;
        kind = K_NONE;
        sel = 2'd0;
        value = 28'd0;
        index = 16'd0;
        failed = 1'b0;
        if (i_first) begin
            s.header = i_byte;
            s.remlen = 28'd0;
            s.digits = 3'd0;
            s.fcount = 16'd0;
            s.slen = 16'd0;
            s.vhdr = 17'd0;
            s.cflags = 8'd0;
            s.tuples = 16'd0;
            s.gfail = 1'b0;
            s.phase = PH_REMLEN;
            s.status = ST_BUSY;
            kind = K_HEADER;
            value = {20'd0, i_byte};
            if (i_last) begin
                s.phase = PH_DONE;
                s.status = ST_OOB;
            end
        end else if (i_st.phase == PH_DONE) begin
            kind = K_STATUS;
        end else if (i_st.phase != PH_IDLE) begin
            // Two-byte fields share the pair capture; string bytes share the counter.
            case (i_st.phase)
                PH_PNAME_LEN, PH_KEEPALIVE, PH_CID_LEN, PH_WTOP_LEN, PH_WMSG_LEN,
                PH_PUB_TLEN, PH_PUB_ID, PH_PKTID, PH_SUB_TLEN, PH_UNS_TLEN: begin
                    s.slen = pair;
                    s.fcount = pair_done ? 16'd0 : 16'd1;
                    value = {12'd0, pair};
                end
                PH_PNAME, PH_CID, PH_WTOP, PH_WMSG, PH_PUB_TOPIC, PH_SUB_TOPIC,
                PH_UNS_TOPIC: begin
                    kind = K_STRING;
                    value = {20'd0, i_byte};
                    s.fcount = str_done ? 16'd0 : fc_inc;
                end
                default: ;
            endcase
            case (i_st.phase)
                PH_REMLEN: begin
                    kind = K_REMLEN;
                    if (i_st.digits >= 3'd4) begin
                        value = i_st.remlen;
                        s.phase = PH_DONE;
                        s.status = ST_MALFORMED;
                    end else begin
                        s.remlen = i_st.remlen + remlen_add;
                        s.digits = i_st.digits + 3'd1;
                        value = s.remlen;
                        if (!i_byte[7]) begin
                            s.fcount = 16'd0;
                            s.status = ST_BUSY;
                            case (ptype)
                                PT_CONNECT: s.phase = PH_PNAME_LEN;
                                PT_CONNACK: begin
                                    if (hflags != 4'd0) begin
                                        s.phase = PH_DONE; s.status = ST_FLAGS;
                                    end else if (s.remlen != 28'd2) begin
                                        s.phase = PH_DONE; s.status = ST_MALFORMED;
                                    end else s.phase = PH_CACK_FLAGS;
                                end
                                PT_PUBLISH: s.phase = PH_PUB_TLEN;
                                PT_PUBACK: begin
                                    if (s.remlen != 28'd2) begin
                                        s.phase = PH_DONE; s.status = ST_MALFORMED;
                                    end else s.phase = PH_PKTID;
                                end
                                PT_SUBSCRIBE, PT_UNSUBSCRIBE: begin
                                    if (hflags != 4'd2) begin
                                        s.phase = PH_DONE; s.status = ST_FLAGS;
                                    end else s.phase = PH_PKTID;
                                end
                                PT_SUBACK: s.phase = PH_PKTID;
                                PT_DISCONNECT: begin
                                    s.phase = PH_DONE;
                                    s.status = (hflags != 4'd0) ? ST_MALFORMED : ST_OK;
                                end
                                default: begin
                                    s.phase = PH_DONE; s.status = ST_UNKNOWN;
                                end
                            endcase
                        end
                    end
                end
                PH_PNAME_LEN:
                    if (pair_done) s.phase = (pair == 16'd0) ? PH_LEVEL : PH_PNAME;
                PH_PNAME:
                    if (str_done) s.phase = PH_LEVEL;
                PH_LEVEL: begin
                    kind = K_LEVEL; value = {20'd0, i_byte}; s.phase = PH_CFLAGS;
                end
                PH_CFLAGS: begin
                    kind = K_FLAGS; value = {20'd0, i_byte};
                    if (i_byte[0]) begin
                        s.phase = PH_DONE; s.status = ST_MALFORMED;
                    end else begin
                        s.cflags = i_byte; s.fcount = 16'd0; s.phase = PH_KEEPALIVE;
                    end
                end
                PH_KEEPALIVE: begin
                    kind = K_KEEPALIVE;
                    if (pair_done) s.phase = PH_CID_LEN;
                end
                PH_CID_LEN: begin
                    sel = 2'd1;
                    if (pair_done) begin
                        if (pair != 16'd0) s.phase = PH_CID;
                        else if (i_st.cflags[2]) s.phase = PH_WTOP_LEN;
                        else begin s.phase = PH_DONE; s.status = ST_OK; end
                    end
                end
                PH_CID: begin
                    sel = 2'd1;
                    if (str_done) begin
                        if (i_st.cflags[2]) s.phase = PH_WTOP_LEN;
                        else begin s.phase = PH_DONE; s.status = ST_OK; end
                    end
                end
                PH_WTOP_LEN: begin
                    sel = 2'd2;
                    if (pair_done) s.phase = (pair == 16'd0) ? PH_WMSG_LEN : PH_WTOP;
                end
                PH_WTOP: begin
                    sel = 2'd2;
                    if (str_done) s.phase = PH_WMSG_LEN;
                end
                PH_WMSG_LEN: begin
                    sel = 2'd3;
                    if (pair_done) begin
                        if (pair == 16'd0) begin s.phase = PH_DONE; s.status = ST_OK; end
                        else s.phase = PH_WMSG;
                    end
                end
                PH_WMSG: begin
                    sel = 2'd3;
                    if (str_done) begin s.phase = PH_DONE; s.status = ST_OK; end
                end
                PH_CACK_FLAGS: begin
                    kind = K_FLAGS; value = {20'd0, i_byte};
                    if (i_byte[7:1] != 7'd0) begin
                        s.phase = PH_DONE; s.status = ST_MALFORMED;
                    end else s.phase = PH_CACK_CODE;
                end
                PH_CACK_CODE: begin
                    kind = K_CODE; value = {20'd0, i_byte};
                    s.phase = PH_DONE; s.status = ST_OK;
                end
                PH_PUB_TLEN, PH_PUB_TOPIC, PH_PUB_ID: begin
                    if (i_st.phase == PH_PUB_ID) kind = K_PKTID;
                    if (i_st.phase == PH_PUB_TLEN && pair_done) begin
                        s.vhdr = 17'd2 + {1'b0, pair};
                        if (pair != 16'd0) s.phase = PH_PUB_TOPIC;
                    end
                    if ((i_st.phase == PH_PUB_TLEN && pair_done && pair == 16'd0) ||
                        (i_st.phase == PH_PUB_TOPIC && str_done) ||
                        (i_st.phase == PH_PUB_ID && pair_done)) begin
                        if (i_st.phase != PH_PUB_ID && i_st.header[2:1] != 2'd0) begin
                            s.phase = PH_PUB_ID; s.fcount = 16'd0;
                        end else if (i_st.phase == PH_PUB_ID && pair == 16'd0) begin
                            s.phase = PH_DONE; s.status = ST_PKTID0;
                        end else begin
                            if (i_st.phase == PH_PUB_ID) s.vhdr = i_st.vhdr + 17'd2;
                            if ({11'd0, s.vhdr} > i_st.remlen) begin
                                s.phase = PH_DONE; s.status = ST_MALFORMED;
                            end else begin
                                s.remlen = i_st.remlen - {11'd0, s.vhdr};
                                if (s.remlen == 28'd0) begin
                                    s.phase = PH_DONE; s.status = ST_OK;
                                end else s.phase = PH_PUB_DATA;
                            end
                        end
                    end
                end
                PH_PUB_DATA: begin
                    kind = K_PAYLOAD; value = {20'd0, i_byte};
                    s.remlen = i_st.remlen - 28'd1;
                    if (s.remlen == 28'd0) begin s.phase = PH_DONE; s.status = ST_OK; end
                end
                PH_PKTID: begin
                    kind = K_PKTID;
                    if (pair_done) begin
                        s.tuples = 16'd0;
                        case (ptype)
                            PT_PUBACK: begin s.phase = PH_DONE; s.status = ST_OK; end
                            PT_SUBSCRIBE: begin
                                s.gfail = (pair == 16'd0); s.phase = PH_SUB_TLEN;
                            end
                            PT_SUBACK: s.phase = PH_SUBACK_CODE;
                            default: begin
                                if (pair == 16'd0) begin
                                    s.phase = PH_DONE; s.status = ST_PKTID0;
                                end else s.phase = PH_UNS_TLEN;
                            end
                        endcase
                    end
                end
                PH_SUB_TLEN: begin
                    index = i_st.tuples; failed = i_st.gfail;
                    if (pair_done) begin
                        if (pair == 16'd0) begin
                            kind = K_TUPLE_END; value = {20'd0, SUBACK_FAILURE};
                            failed = 1'b1; s.tuples = tup_inc;
                        end else s.phase = PH_SUB_TOPIC;
                    end
                end
                PH_SUB_TOPIC: begin
                    index = i_st.tuples; failed = i_st.gfail;
                    if (str_done) s.phase = PH_SUB_QOS;
                end
                PH_SUB_QOS: begin
                    index = i_st.tuples;
                    failed = i_st.gfail || (i_byte > 8'd1);
                    kind = K_TUPLE_END;
                    value = {20'd0, failed ? SUBACK_FAILURE : i_byte};
                    s.tuples = tup_inc; s.fcount = 16'd0; s.phase = PH_SUB_TLEN;
                end
                PH_SUBACK_CODE: begin
                    kind = K_CODE; value = {20'd0, i_byte}; index = i_st.tuples;
                    if (i_byte != 8'd0 && i_byte != 8'd1 && i_byte != 8'd2 &&
                        i_byte != SUBACK_FAILURE) begin
                        s.phase = PH_DONE; s.status = ST_MALFORMED;
                    end else s.tuples = tup_inc;
                end
                PH_UNS_TLEN: begin
                    index = i_st.tuples;
                    if (pair_done) begin
                        if (pair == 16'd0) begin s.phase = PH_DONE; s.status = ST_MALFORMED; end
                        else s.phase = PH_UNS_TOPIC;
                    end
                end
                PH_UNS_TOPIC: begin
                    index = i_st.tuples;
                    if (str_done) begin s.tuples = tup_inc; s.phase = PH_UNS_TLEN; end
                end
                default: ;
            endcase
            // End of buffer closes a packet that still waits for bytes.
            if (i_last && s.phase != PH_DONE) begin
                case (s.phase)
                    PH_PKTID: s.status = (ptype == PT_SUBSCRIBE) ? ST_MALFORMED : ST_OOB;
                    PH_SUB_TLEN: begin
                        if (s.fcount == 16'd0) begin
                            s.status = (s.tuples == 16'd0) ? ST_MALFORMED : ST_OK;
                        end else begin
                            failed = 1'b1;
                            s.tuples = (s.tuples == 16'hFFFF) ? s.tuples : s.tuples + 16'd1;
                            s.status = ST_OK;
                        end
                    end
                    PH_SUB_TOPIC, PH_SUB_QOS: begin
                        failed = 1'b1;
                        s.tuples = (s.tuples == 16'hFFFF) ? s.tuples : s.tuples + 16'd1;
                        s.status = ST_OK;
                    end
                    PH_SUBACK_CODE: s.status = (s.tuples == 16'd0) ? ST_MALFORMED : ST_OK;
                    PH_UNS_TLEN: begin
                        if (s.fcount == 16'd0) begin
                            s.status = (s.tuples == 16'd0) ? ST_MALFORMED : ST_OK;
                        end else s.status = ST_OOB;
                    end
                    default: s.status = ST_OOB;
                endcase
                s.phase = PH_DONE;
            end
        end
        o_st = s;
        o_res.pkind = s.header[7:4];
        o_res.fkind = kind;
        o_res.sel = sel;
        o_res.value = value;
        o_res.index = index;
        o_res.failed = failed;
        o_res.done = (s.phase == PH_DONE);
        o_res.status = (s.phase == PH_DONE) ? s.status : ST_BUSY;
    end
endmodule

>>> tb/mqtt_control_packet_parser_tb.sv
// Testbench for the MQTT control packet parser: directed and random packet buffers.
// Depends on mqtt_pkg and the parser RTL; a behavioral parser model predicts each result.
`timescale 1ns / 1ps

class mqtt_result_board;
    mqtt_pkg::t_result pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note_byte(mqtt_pkg::t_result r);
        pending.push_back(r);
    endfunction

    function void check_result(mqtt_pkg::t_result got);
        mqtt_pkg::t_result exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            errors++;
        end
    endfunction
endclass

module mqtt_control_packet_parser_tb;
    import mqtt_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 0;
    logic        i_first_byte = 0;
    logic        i_end_of_buffer = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [3:0]  o_packet_kind;
    logic [3:0]  o_field_kind;
    logic [1:0]  o_string_select;
    logic [27:0] o_field_value;
    logic [15:0] o_tuple_index;
    logic        o_tuple_failed;
    logic [2:0]  o_parse_status;
    logic        o_packet_done;

    mqtt_control_packet_parser uut (.*);

    always #4 i_clk = ~i_clk;

    mqtt_result_board board = new();

    // Parser model state.
    int unsigned phase, hdr, remlen, digits, fcount, slen, vhdr, cflags, tuples, gfail, verdict;
    int unsigned rk, rsel, rval, ridx, rfail;
    int unsigned idle_cycles;
    logic quiet_rx;
    byte unsigned pkt[$];

    localparam int unsigned P_IDLE = 0, P_REMLEN = 1, P_PNL = 2, P_PN = 3, P_LEVEL = 4,
        P_CFLAGS = 5, P_KA = 6, P_CIDL = 7, P_CID = 8, P_WTL = 9, P_WT = 10, P_WML = 11,
        P_WM = 12, P_CAF = 13, P_CAC = 14, P_PTL = 15, P_PT = 16, P_PID = 17, P_PD = 18,
        P_PKTID = 19, P_STL = 20, P_ST = 21, P_SQ = 22, P_SAC = 23, P_UTL = 24, P_UT = 25,
        P_DONE = 26;

    function void conclude(int unsigned s);
        phase = P_DONE;
        verdict = s;
    endfunction

    function void bump_tuples();
        if (tuples < 16'hFFFF) tuples++;
    endfunction

    function bit take_pair(int unsigned b);
        if (fcount == 0) begin
            slen = (b << 8) & 16'hFFFF;
            fcount = 1;
            rval = slen;
            return 0;
        end
        slen = (slen | b) & 16'hFFFF;
        fcount = 0;
        rval = slen;
        return 1;
    endfunction

    function bit take_char(int unsigned b);
        rk = K_STRING;
        rval = b;
        fcount++;
        if (fcount >= slen) begin
            fcount = 0;
            return 1;
        end
        return 0;
    endfunction

    function void open_string(int unsigned sp, int unsigned ep);
        fcount = 0;
        phase = (slen == 0) ? ep : sp;
    endfunction

    function void after_cid();
        if (cflags & 4) phase = P_WTL;
        else conclude(ST_OK);
    endfunction

    function void enter_payload();
        if (vhdr > remlen) begin
            conclude(ST_MALFORMED);
            return;
        end
        remlen -= vhdr;
        if (remlen == 0) conclude(ST_OK);
        else phase = P_PD;
    endfunction

    function void after_topic();
        if (((hdr >> 1) & 3) != 0) begin
            phase = P_PID;
            fcount = 0;
        end else enter_payload();
    endfunction

    function void route_packet();
        int unsigned fl;
        fl = hdr & 15;
        fcount = 0;
        case (hdr >> 4)
            PT_CONNECT: phase = P_PNL;
            PT_CONNACK: begin
                if (fl != 0) conclude(ST_FLAGS);
                else if (remlen != 2) conclude(ST_MALFORMED);
                else phase = P_CAF;
            end
            PT_PUBLISH: phase = P_PTL;
            PT_PUBACK: begin
                if (remlen != 2) conclude(ST_MALFORMED);
                else phase = P_PKTID;
            end
            PT_SUBSCRIBE, PT_UNSUBSCRIBE: begin
                if (fl != 2) conclude(ST_FLAGS);
                else phase = P_PKTID;
            end
            PT_SUBACK: phase = P_PKTID;
            PT_DISCONNECT: conclude(fl != 0 ? ST_MALFORMED : ST_OK);
            default: conclude(ST_UNKNOWN);
        endcase
    endfunction

    function void close_buffer();
        case (phase)
            P_PKTID: conclude((hdr >> 4) == PT_SUBSCRIBE ? ST_MALFORMED : ST_OOB);
            P_STL: begin
                if (fcount == 0) conclude(tuples == 0 ? ST_MALFORMED : ST_OK);
                else begin
                    rfail = 1;
                    bump_tuples();
                    conclude(ST_OK);
                end
            end
            P_ST, P_SQ: begin
                rfail = 1;
                bump_tuples();
                conclude(ST_OK);
            end
            P_SAC: conclude(tuples == 0 ? ST_MALFORMED : ST_OK);
            P_UTL: begin
                if (fcount == 0) conclude(tuples == 0 ? ST_MALFORMED : ST_OK);
                else conclude(ST_OOB);
            end
            default: conclude(ST_OOB);
        endcase
    endfunction

    function void consume_byte(int unsigned b);
        int unsigned q;
        case (phase)
            P_REMLEN: begin
                rk = K_REMLEN;
                if (digits >= 4) begin
                    rval = remlen;
                    conclude(ST_MALFORMED);
                end else begin
                    remlen += (b & 127) << (7 * digits);
                    digits++;
                    rval = remlen;
                    if ((b & 128) == 0) route_packet();
                end
            end
            P_PNL: if (take_pair(b)) open_string(P_PN, P_LEVEL);
            P_PN: if (take_char(b)) phase = P_LEVEL;
            P_LEVEL: begin
                rk = K_LEVEL;
                rval = b;
                phase = P_CFLAGS;
            end
            P_CFLAGS: begin
                rk = K_FLAGS;
                rval = b;
                if (b & 1) conclude(ST_MALFORMED);
                else begin
                    cflags = b;
                    fcount = 0;
                    phase = P_KA;
                end
            end
            P_KA: begin
                rk = K_KEEPALIVE;
                if (take_pair(b)) phase = P_CIDL;
            end
            P_CIDL: begin
                rsel = 1;
                if (take_pair(b)) begin
                    if (slen == 0) after_cid();
                    else open_string(P_CID, P_CID);
                end
            end
            P_CID: begin
                rsel = 1;
                if (take_char(b)) after_cid();
            end
            P_WTL: begin
                rsel = 2;
                if (take_pair(b)) open_string(P_WT, P_WML);
            end
            P_WT: begin
                rsel = 2;
                if (take_char(b)) phase = P_WML;
            end
            P_WML: begin
                rsel = 3;
                if (take_pair(b)) begin
                    if (slen == 0) conclude(ST_OK);
                    else open_string(P_WM, P_WM);
                end
            end
            P_WM: begin
                rsel = 3;
                if (take_char(b)) conclude(ST_OK);
            end
            P_CAF: begin
                rk = K_FLAGS;
                rval = b;
                if (b & 8'hFE) conclude(ST_MALFORMED);
                else phase = P_CAC;
            end
            P_CAC: begin
                rk = K_CODE;
                rval = b;
                conclude(ST_OK);
            end
            P_PTL: begin
                if (take_pair(b)) begin
                    vhdr = 2 + slen;
                    if (slen == 0) after_topic();
                    else open_string(P_PT, P_PT);
                end
            end
            P_PT: if (take_char(b)) after_topic();
            P_PID: begin
                rk = K_PKTID;
                if (take_pair(b)) begin
                    if (slen == 0) conclude(ST_PKTID0);
                    else begin
                        vhdr += 2;
                        enter_payload();
                    end
                end
            end
            P_PD: begin
                rk = K_PAYLOAD;
                rval = b;
                remlen--;
                if (remlen == 0) conclude(ST_OK);
            end
            P_PKTID: begin
                rk = K_PKTID;
                if (take_pair(b)) begin
                    tuples = 0;
                    q = hdr >> 4;
                    if (q == PT_PUBACK) conclude(ST_OK);
                    else if (q == PT_SUBSCRIBE) begin
                        gfail = (slen == 0);
                        phase = P_STL;
                    end else if (q == PT_SUBACK) phase = P_SAC;
                    else if (slen == 0) conclude(ST_PKTID0);
                    else phase = P_UTL;
                end
            end
            P_STL: begin
                ridx = tuples;
                rfail = gfail;
                if (take_pair(b)) begin
                    if (slen == 0) begin
                        rk = K_TUPLE_END;
                        rval = SUBACK_FAILURE;
                        rfail = 1;
                        bump_tuples();
                    end else open_string(P_ST, P_ST);
                end
            end
            P_ST: begin
                ridx = tuples;
                rfail = gfail;
                if (take_char(b)) phase = P_SQ;
            end
            P_SQ: begin
                ridx = tuples;
                rfail = (gfail != 0 || b > 1);
                rk = K_TUPLE_END;
                rval = rfail ? SUBACK_FAILURE : b;
                bump_tuples();
                fcount = 0;
                phase = P_STL;
            end
            P_SAC: begin
                rk = K_CODE;
                rval = b;
                ridx = tuples;
                if (b != 0 && b != 1 && b != 2 && b != SUBACK_FAILURE) conclude(ST_MALFORMED);
                else bump_tuples();
            end
            P_UTL: begin
                ridx = tuples;
                if (take_pair(b)) begin
                    if (slen == 0) conclude(ST_MALFORMED);
                    else open_string(P_UT, P_UT);
                end
            end
            P_UT: begin
                ridx = tuples;
                if (take_char(b)) begin
                    bump_tuples();
                    phase = P_UTL;
                end
            end
            default: ;
        endcase
    endfunction

    function t_result predict_byte(int unsigned b, bit first, bit last);
        t_result r;
        rk = K_NONE; rsel = 0; rval = 0; ridx = 0; rfail = 0;
        if (first) begin
            hdr = b; remlen = 0; digits = 0; fcount = 0; slen = 0; vhdr = 0;
            cflags = 0; tuples = 0; gfail = 0;
            phase = P_REMLEN;
            rk = K_HEADER;
            rval = b;
            if (last) conclude(ST_OOB);
        end else if (phase == P_DONE) begin
            rk = K_STATUS;
        end else if (phase != P_IDLE) begin
            consume_byte(b);
            if (last && phase != P_DONE) close_buffer();
        end
        r.pkind = hdr[7:4];
        r.fkind = rk[3:0];
        r.sel = rsel[1:0];
        r.value = rval[27:0];
        r.index = ridx[15:0];
        r.failed = rfail[0];
        r.status = (phase == P_DONE) ? verdict[2:0] : ST_BUSY;
        r.done = (phase == P_DONE);
        return r;
    endfunction

    function int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Result side: random stalls, sampled at the edge.
    int unsigned rx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result({o_packet_kind, o_field_kind, o_string_select, o_field_value,
                                o_tuple_index, o_tuple_failed, o_parse_status, o_packet_done});
        end
        if (quiet_rx) i_ready <= 1'b1;
        else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            rx_gap <= pick_gap();
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("mqtt_control_packet_parser_tb failed");
                $finish;
            end
        end
    end

    // Valid stays high across back-to-back bytes and drops only for a gap.
    task automatic send_byte(input byte unsigned b, input bit first, input bit last);
        int unsigned g;
        g = pick_gap();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_first_byte <= first;
        i_end_of_buffer <= last;
        do @(posedge i_clk); while (!o_ready);
        board.note_byte(predict_byte(b, first, last));
    endtask

    // Sends pkt as one buffer; the first byte is the fixed header.
    task automatic send_buffer();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == 0, i == pkt.size() - 1);
    endtask

    task automatic put_string(input int unsigned n);
        pkt.push_back(n >> 8);
        pkt.push_back(n & 255);
        repeat (n) pkt.push_back($urandom_range(0, 255));
    endtask

    task automatic put_remlen(input int unsigned v);
        do begin
            pkt.push_back((v & 127) | ((v > 127) ? 128 : 0));
            v = v >> 7;
        end while (v != 0);
    endtask

    // Builds a mostly well-formed packet of a random type, then maybe breaks it.
    task automatic build_packet();
        byte unsigned body[$];
        int unsigned kind, n, fl, i;
        pkt = {};
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                fl = $urandom_range(0, 255) & ((($urandom_range(0, 9)) == 0) ? 255 : 8'hFE);
                pkt = {8'h00, 8'h04, "M", "Q", "T", "T", 8'h04};
                pkt.push_back(fl);
                pkt.push_back($urandom_range(0, 255));
                pkt.push_back($urandom_range(0, 255));
                put_string($urandom_range(0, 5));
                if (fl & 4) begin
                    put_string($urandom_range(0, 4));
                    put_string($urandom_range(0, 4));
                end
                body = pkt;
                pkt = {8'h10};
            end
            1: begin
                body = {byte'($urandom_range(0, 1)), byte'($urandom_range(0, 255))};
                pkt = {8'h20};
            end
            2, 3: begin
                fl = $urandom_range(0, 15);
                put_string($urandom_range(0, 4));
                if (fl & 6) begin
                    pkt.push_back($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
                    pkt.push_back($urandom_range(0, 255));
                end
                repeat ($urandom_range(0, 6)) pkt.push_back($urandom_range(0, 255));
                body = pkt;
                pkt = {byte'(8'h30 | fl)};
            end
            4: begin
                body = {byte'($urandom_range(0, 255)), byte'($urandom_range(0, 255))};
                pkt = {8'h40};
            end
            5: begin
                pkt.push_back($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 255));
                pkt.push_back($urandom_range(0, 255));
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) begin
                    put_string($urandom_range(0, 3));
                    pkt.push_back($urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 1));
                end
                body = pkt;
                pkt = {8'h82};
            end
            6: begin
                pkt.push_back($urandom_range(0, 255));
                pkt.push_back($urandom_range(0, 255));
                repeat ($urandom_range(0, 4))
                    pkt.push_back($urandom_range(0, 5) == 0 ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 2));
                body = pkt;
                pkt = {8'h90};
            end
            7: begin
                pkt.push_back($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 255));
                pkt.push_back($urandom_range(0, 255));
                repeat ($urandom_range(0, 3)) put_string($urandom_range(0, 3));
                body = pkt;
                pkt = {8'hA2};
            end
            8: begin
                body = {};
                pkt = {byte'($urandom_range(0, 3) == 0 ? 8'hE0 | $urandom_range(0, 15) : 8'hE0)};
            end
            default: begin
                body = {};
                repeat ($urandom_range(0, 4)) body.push_back($urandom_range(0, 255));
                pkt = {byte'($urandom_range(0, 255))};
            end
        endcase
        // Occasionally corrupt the header flags.
        if ($urandom_range(0, 9) == 0) pkt[0] = pkt[0] ^ $urandom_range(1, 15);
        put_remlen(($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : body.size());
        foreach (body[k]) pkt.push_back(body[k]);
        // Truncate or extend the buffer now and then.
        if ($urandom_range(0, 6) == 0 && pkt.size() > 1)
            pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
        else if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) pkt.push_back($urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    int unsigned sent;

    initial begin
        phase = P_IDLE; hdr = 0; remlen = 0; digits = 0; fcount = 0; slen = 0;
        vhdr = 0; cflags = 0; tuples = 0; gfail = 0; verdict = 0;
        quiet_rx = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes before any header, then a header that is also the last byte.
        send_byte(8'hFF, 0, 0);
        send_byte(8'h00, 0, 1);
        send_byte(8'h10, 1, 1);
        send_byte(8'h55, 0, 0);
        // Five remaining-length bytes are malformed.
        pkt = {8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_buffer();
        // Connect with will, empty strings, then bytes after the verdict.
        pkt = {8'h10, 8'h0A, 8'h00, 8'h00, 8'h04, 8'h06, 8'h00, 8'h3C,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA};
        send_buffer();
        // Subscribe with a zero topic length and a bad QoS.
        pkt = {8'h82, 8'h0A, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h02};
        send_buffer();

        // Sender holds off until all results are back.
        wait_drained();

        for (sent = 0; sent < 1000; sent += pkt.size()) begin
            quiet_rx = ($urandom_range(0, 19) == 0);
            build_packet();
            send_buffer();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("mqtt_control_packet_parser_tb passed");
        else
            $display("mqtt_control_packet_parser_tb failed");
        $finish;
    end
endmodule
